[rtl/kvrp_pkg.sv]
// Package for the key/value record parser: character codes, result kinds,
// parse phase codes, queue entry types and the escape decoding helpers.
// No dependencies.
`default_nettype none

package kvrp_pkg;

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_KEY  = 3'd0;
  localparam kind_t KIND_VAL  = 3'd1;
  localparam kind_t KIND_PAIR = 3'd2;
  localparam kind_t KIND_REC  = 3'd3;
  localparam kind_t KIND_ERR  = 3'd4;

  // Parse phases
  typedef logic [3:0] phase_t;
  localparam phase_t PH_OPEN     = 4'd0;
  localparam phase_t PH_PAIR     = 4'd1;
  localparam phase_t PH_UKEY     = 4'd2;
  localparam phase_t PH_QKEY     = 4'd3;
  localparam phase_t PH_QKEY_END = 4'd4;
  localparam phase_t PH_VAL      = 4'd5;
  localparam phase_t PH_UVAL     = 4'd6;
  localparam phase_t PH_QVAL     = 4'd7;
  localparam phase_t PH_QVAL_END = 4'd8;
  localparam phase_t PH_DONE     = 4'd9;

  // Escape progress: hexits still owed
  localparam logic [1:0] HEX_NONE = 2'd0;
  localparam logic [1:0] HEX_LOW  = 2'd1;
  localparam logic [1:0] HEX_HIGH = 2'd2;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  // One queued input byte: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [1:0] hp;
    logic [3:0] high;
  } text_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || ((c >= CH_LF) && (c <= CH_CR));
  endfunction

  // Upper-case hexit; other bytes wrap modulo 256
  function automatic logic [7:0] hexit(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      return c - CH_ZERO;
    end
    return c - CH_UPPERA + 8'd10;
  endfunction

  // One byte of key or value text through the escape decoder
  function automatic text_t text_step(input logic [1:0] hp, input logic [3:0] high,
                                      input logic [7:0] c);
    text_t      t;
    logic [7:0] h;
    h      = hexit(c);
    t.emit = 1'b0;
    t.data = c;
    t.hp   = hp;
    t.high = high;
    case (hp)
      HEX_NONE: begin
        if (c == CH_BSLASH) t.hp = HEX_HIGH;
        else t.emit = 1'b1;
      end
      HEX_HIGH: begin
        t.high = h[3:0];
        t.hp   = HEX_LOW;
      end
      default: begin
        t.emit = 1'b1;
        t.data = {high, 4'b0000} + h;
        t.hp   = HEX_NONE;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/key_value_record_parser.sv]
// Key/value record parser top level: parse state update and result queue.
// Depends on kvrp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one raw character per transfer,
//   in_last on the final byte of a record; the parser returns to its
//   reset state after that byte.
//   Output channel (out_valid/out_ready): one result per transfer, with
//   kind, out_byte and out_last (set on the last result of an input byte).
//   Each input byte gives zero, one or two results.
// Timing:
//   The parse state is updated in the cycle a byte is transferred; its
//   results are visible from the cycle after, from a two-entry result queue.
//   Throughput is one byte per cycle while the queue has room; a byte
//   giving two results shows them one after the other. The queue holds up
//   to two bytes' results while the receiver stalls; in_ready drops when it
//   holds two bytes and the last result of the head byte is not taken in that cycle.
// Reset:
//   rst (synchronous) returns the parser to waiting for the opening brace
//   and empties the queue.
`default_nettype none

module key_value_record_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_byte,
  input  wire                   in_last,
  output logic                  out_valid,
  input  wire                   out_ready,
  output kvrp_pkg::kind_t       kind,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import kvrp_pkg::*;

  localparam logic [1:0] Q_FULL = 2'd2;

  // Parse state
  phase_t     phase, phase_next;
  logic [1:0] hp, hp_next;
  logic [3:0] high, high_next;
  logic       err_seen, err_seen_next;
  logic       done, done_next;

  // Result candidates in output order: text, pair end, record end, error
  logic       c_text, c_pair, c_rec, c_err;
  res_t       text_res;
  logic [3:0] cand_v;
  res_t       cand [4];
  res_t       slot0, slot1;
  logic [1:0] n_res;
  text_t      ts;
  logic       ws;

  // Result queue
  item_t      q [2];
  logic       wp, rp, sub;
  logic [1:0] cnt;
  item_t      head;
  logic       in_fire, out_fire, push, pop;

  always_comb begin
    ws            = is_space(in_byte);
    ts            = text_step(hp, high, in_byte);
    phase_next    = phase;
    hp_next       = hp;
    high_next     = high;
    err_seen_next = err_seen;
    done_next     = done;
    c_text        = 1'b0;
    c_pair        = 1'b0;
    c_rec         = 1'b0;
    c_err         = 1'b0;
    text_res.kind = KIND_KEY;
    text_res.data = ts.data;

    if (!err_seen && !done) begin
      unique case (phase)
        PH_OPEN: begin
          if (in_byte == CH_LBRACE) phase_next = PH_PAIR;
          else if (!ws) c_err = 1'b1;
        end
        PH_PAIR: begin
          if (!ws) begin
            if (in_byte == CH_RBRACE) begin
              c_rec      = 1'b1;
              done_next  = 1'b1;
              phase_next = PH_DONE;
            end else if (in_byte == CH_QUOTE) begin
              phase_next = PH_QKEY;
            end else if (in_byte == CH_EQ) begin
              phase_next = PH_VAL;
            end else begin
              phase_next = PH_UKEY;
              c_text     = ts.emit;
              hp_next    = ts.hp;
              high_next  = ts.high;
            end
          end
        end
        PH_UKEY, PH_QKEY: begin
          // Unquoted keys drop whitespace; quoted keys keep it
          if (!(ws && (phase == PH_UKEY))) begin
            if ((phase == PH_UKEY) ? (in_byte == CH_EQ) : (in_byte == CH_QUOTE)) begin
              if (hp != HEX_NONE) c_err = 1'b1;
              else phase_next = (phase == PH_UKEY) ? PH_VAL : PH_QKEY_END;
            end else begin
              c_text    = ts.emit;
              hp_next   = ts.hp;
              high_next = ts.high;
            end
          end
        end
        PH_QKEY_END: begin
          if (!ws) begin
            if (in_byte == CH_EQ) phase_next = PH_VAL;
            else c_err = 1'b1;
          end
        end
        PH_VAL: begin
          text_res.kind = KIND_VAL;
          if (!ws) begin
            if (in_byte == CH_QUOTE) begin
              phase_next = PH_QVAL;
            end else if ((in_byte == CH_COMMA) || (in_byte == CH_RBRACE)) begin
              c_pair = 1'b1;
            end else begin
              phase_next = PH_UVAL;
              c_text     = ts.emit;
              hp_next    = ts.hp;
              high_next  = ts.high;
            end
          end
        end
        PH_UVAL: begin
          text_res.kind = KIND_VAL;
          if (!ws) begin
            if ((in_byte == CH_COMMA) || (in_byte == CH_RBRACE)) begin
              if (hp != HEX_NONE) c_err = 1'b1;
              else c_pair = 1'b1;
            end else begin
              c_text    = ts.emit;
              hp_next   = ts.hp;
              high_next = ts.high;
            end
          end
        end
        PH_QVAL: begin
          text_res.kind = KIND_VAL;
          if (in_byte == CH_QUOTE) begin
            if (hp != HEX_NONE) c_err = 1'b1;
            else phase_next = PH_QVAL_END;
          end else begin
            c_text    = ts.emit;
            hp_next   = ts.hp;
            high_next = ts.high;
          end
        end
        PH_QVAL_END: begin
          if (!ws) begin
            if ((in_byte == CH_COMMA) || (in_byte == CH_RBRACE)) c_pair = 1'b1;
            else c_err = 1'b1;
          end
        end
        default: c_err = 1'b1;
      endcase

      // End of a value: pair mark, and record mark on the closing brace
      if (c_pair) begin
        if (in_byte == CH_RBRACE) begin
          c_rec      = 1'b1;
          done_next  = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_PAIR;
        end
      end
      if (c_err) begin
        err_seen_next = 1'b1;
        hp_next       = HEX_NONE;
      end
    end

    // Last byte: error if the record is cut short, then back to the reset state
    if (in_last) begin
      if (!err_seen_next && !done_next) c_err = 1'b1;
      phase_next    = PH_OPEN;
      hp_next       = HEX_NONE;
      high_next     = 4'd0;
      err_seen_next = 1'b0;
      done_next     = 1'b0;
    end

    cand_v  = {c_err, c_rec, c_pair, c_text};
    cand[0] = text_res;
    cand[1] = '{kind: KIND_PAIR, data: 8'd0};
    cand[2] = '{kind: KIND_REC, data: 8'd0};
    cand[3] = '{kind: KIND_ERR, data: 8'd0};
    slot0   = '{kind: KIND_KEY, data: 8'd0};
    slot1   = '{kind: KIND_KEY, data: 8'd0};
    n_res   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n_res == 2'd0) slot0 = cand[i];
        else slot1 = cand[i];
        n_res = n_res + 2'd1;
      end
    end
  end

  // Output side
  assign head      = q[rp];
  assign out_valid = (cnt != 2'd0);
  assign kind      = sub ? head.r1.kind : head.r0.kind;
  assign out_byte  = sub ? head.r1.data : head.r0.data;
  assign out_last  = !head.two || sub;
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && out_last;

  assign in_ready  = (cnt != Q_FULL) || pop;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && (n_res != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPEN;
      hp       <= HEX_NONE;
      high     <= 4'd0;
      err_seen <= 1'b0;
      done     <= 1'b0;
      cnt      <= 2'd0;
      wp       <= 1'b0;
      rp       <= 1'b0;
      sub      <= 1'b0;
    end else begin
      if (in_fire) begin
        phase    <= phase_next;
        hp       <= hp_next;
        high     <= high_next;
        err_seen <= err_seen_next;
        done     <= done_next;
      end
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (out_fire) sub <= !out_last;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{two: (n_res == 2'd2), r0: slot0, r1: slot1};
    end
  end

endmodule

`default_nettype wire

[rtl/kvrp_checker.sv]
// Port-level checks for the key/value record parser, bound to the top level.
// Depends on kvrp_pkg and key_value_record_parser.
`default_nettype none

module kvrp_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire kvrp_pkg::kind_t kind,
  input wire [7:0]            out_byte,
  input wire                  out_last
);
  import kvrp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(out_last))
    else $error("result changed while stalled");

  // Nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Marks carry no byte
  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_PAIR || kind == KIND_REC || kind == KIND_ERR)
      |-> out_byte == 8'd0)
    else $error("mark with nonzero byte");

  // An error is always the last result of its byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> out_last)
    else $error("error result not last");

  // A pair end that is not last is followed at once by a record end or error
  a_pair_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_PAIR && !out_last
      |=> out_valid && (kind == KIND_REC || kind == KIND_ERR))
    else $error("pair end not followed by record end or error");

endmodule

bind key_value_record_parser kvrp_checker u_kvrp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for key_value_record_parser: directed rows, then random
// well-formed, broken and noise records, predicted by a local parser model.
// Depends on kvrp_pkg and the key_value_record_parser RTL.
`default_nettype none

module testbench;
  import kvrp_pkg::*;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int DIR_ROWS     = 28;
  localparam int RANDOM_BYTES = 700;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       lst;
  } result_t;

  // fixed = 1: results typed in below (all marks or errors, byte zero)
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       fixed;
    logic [1:0] n;
    kind_t      k0;
    kind_t      k1;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ready;
  wire        in_ready;
  wire        out_valid;
  kind_t      kind;
  wire  [7:0] out_byte;
  wire        out_last;

  key_value_record_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{" ",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},  // space before brace
    '{"Q",       1'b0, 1'b1, 2'd1, KIND_ERR,  KIND_ERR},  // wrong opening
    '{8'hFF,     1'b1, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},  // ignored after error
    '{"{",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
    '{"=",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},  // empty key
    '{",",       1'b0, 1'b1, 2'd1, KIND_PAIR, KIND_PAIR}, // empty value
    '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{" ",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},  // kept inside quotes
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"F",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"F",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{CH_TAB,    1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"=",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"0",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"0",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"}",       1'b0, 1'b1, 2'd2, KIND_PAIR, KIND_REC},
    '{"x",       1'b1, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},  // ignored after record end
    '{"{",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
    '{"}",       1'b1, 1'b1, 2'd1, KIND_REC,  KIND_REC},  // close at pair start
    '{"{",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
    '{"k",       1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_KEY,  KIND_KEY},
    '{"=",       1'b0, 1'b1, 2'd1, KIND_ERR,  KIND_ERR},  // escape cut short
    '{8'h00,     1'b1, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
    '{"{",       1'b0, 1'b1, 2'd0, KIND_KEY,  KIND_KEY},
    '{"v",       1'b1, 1'b0, 2'd0, KIND_KEY,  KIND_KEY}   // truncated record
  };

  // parser model state
  phase_t     ps_phase;
  logic [1:0] ps_owed;
  logic [3:0] ps_high;
  logic       ps_err;
  logic       ps_done;
  result_t    step_res [2];
  int         step_cnt;

  result_t    due_results [$];
  in_item_t   byte_stream [$];
  logic [7:0] rec_bytes [$];
  result_t    head;

  logic quiet;
  logic calm;
  logic ready_next;
  int   ready_left;
  int   n_sent;
  int   n_checked;
  int   n_records;
  int   n_errors;

  function automatic logic ws_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    return c - CH_UPPERA + 8'd10;
  endfunction

  function automatic void add_result(input kind_t k, input logic [7:0] d);
    if (step_cnt < 2) begin
      step_res[step_cnt] = '{kind: k, data: d, lst: 1'b0};
      step_cnt++;
    end
  endfunction

  function automatic void fail_parse();
    add_result(KIND_ERR, 8'h00);
    ps_err  = 1'b1;
    ps_owed = HEX_NONE;
  endfunction

  function automatic void reset_parser();
    ps_phase = PH_OPEN;
    ps_owed  = HEX_NONE;
    ps_high  = 4'h0;
    ps_err   = 1'b0;
    ps_done  = 1'b0;
  endfunction

  function automatic void text_char(input kind_t k, input logic [7:0] c);
    logic [7:0] hv;
    hv = hex_value(c);
    case (ps_owed)
      HEX_NONE: begin
        if (c == CH_BSLASH) ps_owed = HEX_HIGH;
        else add_result(k, c);
      end
      HEX_HIGH: begin
        ps_high = hv[3:0];
        ps_owed = HEX_LOW;
      end
      default: begin
        add_result(k, {ps_high, 4'b0000} + hv);
        ps_owed = HEX_NONE;
      end
    endcase
  endfunction

  // delimiter while hexits are owed is an error
  function automatic logic close_ok();
    if (ps_owed != HEX_NONE) begin
      fail_parse();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void end_pair(input logic [7:0] c);
    add_result(KIND_PAIR, 8'h00);
    if (c == CH_RBRACE) begin
      add_result(KIND_REC, 8'h00);
      ps_done  = 1'b1;
      ps_phase = PH_DONE;
    end else begin
      ps_phase = PH_PAIR;
    end
  endfunction

  // results of one byte land in step_res/step_cnt
  function automatic void parse_byte(input logic [7:0] c, input logic l);
    logic ws;
    ws       = ws_byte(c);
    step_cnt = 0;
    if (!ps_err && !ps_done) begin
      case (ps_phase)
        PH_OPEN: begin
          if (c == CH_LBRACE) ps_phase = PH_PAIR;
          else if (!ws) fail_parse();
        end
        PH_PAIR: begin
          if (!ws) begin
            if (c == CH_RBRACE) begin
              add_result(KIND_REC, 8'h00);
              ps_done  = 1'b1;
              ps_phase = PH_DONE;
            end else if (c == CH_QUOTE) begin
              ps_phase = PH_QKEY;
            end else if (c == CH_EQ) begin
              ps_phase = PH_VAL;
            end else begin
              ps_phase = PH_UKEY;
              text_char(KIND_KEY, c);
            end
          end
        end
        PH_UKEY: begin
          if (!ws) begin
            if (c == CH_EQ) begin
              if (close_ok()) ps_phase = PH_VAL;
            end else begin
              text_char(KIND_KEY, c);
            end
          end
        end
        PH_QKEY: begin
          if (c == CH_QUOTE) begin
            if (close_ok()) ps_phase = PH_QKEY_END;
          end else begin
            text_char(KIND_KEY, c);
          end
        end
        PH_QKEY_END: begin
          if (!ws) begin
            if (c == CH_EQ) ps_phase = PH_VAL;
            else fail_parse();
          end
        end
        PH_VAL: begin
          if (!ws) begin
            if (c == CH_QUOTE) begin
              ps_phase = PH_QVAL;
            end else if (c == CH_COMMA || c == CH_RBRACE) begin
              end_pair(c);
            end else begin
              ps_phase = PH_UVAL;
              text_char(KIND_VAL, c);
            end
          end
        end
        PH_UVAL: begin
          if (!ws) begin
            if (c == CH_COMMA || c == CH_RBRACE) begin
              if (close_ok()) end_pair(c);
            end else begin
              text_char(KIND_VAL, c);
            end
          end
        end
        PH_QVAL: begin
          if (c == CH_QUOTE) begin
            if (close_ok()) ps_phase = PH_QVAL_END;
          end else begin
            text_char(KIND_VAL, c);
          end
        end
        PH_QVAL_END: begin
          if (!ws) begin
            if (c == CH_COMMA || c == CH_RBRACE) end_pair(c);
            else fail_parse();
          end
        end
        default: fail_parse();
      endcase
    end
    if (l) begin
      if (!ps_err && !ps_done) fail_parse();
      reset_parser();
    end
    if (step_cnt > 0) step_res[step_cnt - 1].lst = 1'b1;
  endfunction

  // random record text
  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void add_ws();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) rec_bytes.push_back(pick_ws());
    end
  endfunction

  function automatic logic [7:0] hex_digit();
    logic [3:0] v;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    v = 4'($urandom_range(0, 15));
    return (v < 10) ? CH_ZERO + v : CH_UPPERA + v - 8'd10;
  endfunction

  function automatic logic [7:0] text_fill(input logic quoted);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h21, 8'h7E));
    end while (c == CH_QUOTE || c == CH_BSLASH ||
               (!quoted && (c == CH_EQ || c == CH_COMMA || c == CH_RBRACE)));
    return c;
  endfunction

  function automatic void add_text(input logic quoted);
    int len;
    len = $urandom_range(0, 4);
    for (int j = 0; j < len; j++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          rec_bytes.push_back(CH_BSLASH);
          rec_bytes.push_back(hex_digit());
          rec_bytes.push_back(hex_digit());
        end
        2: rec_bytes.push_back(pick_ws());
        default: rec_bytes.push_back(text_fill(quoted));
      endcase
    end
  endfunction

  function automatic void add_record();
    int style;
    int npairs;
    int cut;
    rec_bytes.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      // pure noise
      repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) add_ws();
      rec_bytes.push_back(CH_LBRACE);
      npairs = $urandom_range(0, 3);
      for (int p = 0; p < npairs; p++) begin
        add_ws();
        if ($urandom_range(0, 1) == 0) begin
          rec_bytes.push_back(CH_QUOTE);
          add_text(1'b1);
          rec_bytes.push_back(CH_QUOTE);
        end else begin
          add_text(1'b0);
        end
        add_ws();
        rec_bytes.push_back(CH_EQ);
        add_ws();
        case ($urandom_range(0, 2))
          0: ;
          1: begin
            rec_bytes.push_back(CH_QUOTE);
            add_text(1'b1);
            rec_bytes.push_back(CH_QUOTE);
          end
          default: add_text(1'b0);
        endcase
        add_ws();
        if (p < npairs - 1) rec_bytes.push_back(CH_COMMA);
      end
      rec_bytes.push_back(CH_RBRACE);
      case (style)
        1: rec_bytes[$urandom_range(0, rec_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        2: begin
          cut = $urandom_range(1, rec_bytes.size());
          while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        end
        3: repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    for (int j = 0; j < rec_bytes.size(); j++) begin
      byte_stream.push_back('{ch: rec_bytes[j], lst: (j == rec_bytes.size() - 1)});
    end
  endfunction

  // sender side
  task automatic sender_gap();
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic l, input logic fixed,
                           input logic [1:0] n, input kind_t k0, input kind_t k1);
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= l;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    // transfer happens at the coming edge
    parse_byte(c, l);
    if (fixed) begin
      for (int i = 0; i < n; i++) begin
        due_results.push_back('{kind: (i == 0) ? k0 : k1, data: 8'h00, lst: (i == n - 1)});
      end
    end else begin
      for (int i = 0; i < step_cnt; i++) due_results.push_back(step_res[i]);
    end
    n_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    out_ready = 1'b0;
    quiet     = 1'b0;
    calm      = 1'b0;
    n_sent    = 0;
    reset_parser();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      sender_gap();
      send_byte(directed_rows[i].ch, directed_rows[i].lst, directed_rows[i].fixed,
                directed_rows[i].n, directed_rows[i].k0, directed_rows[i].k1);
    end
    wait_drained();

    while (byte_stream.size() < RANDOM_BYTES) add_record();
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i == byte_stream.size() / 2) wait_drained();
      if (i >= byte_stream.size() * 85 / 100) quiet = 1'b1;
      sender_gap();
      send_byte(byte_stream[i].ch, byte_stream[i].lst, 1'b0, 2'd0, KIND_KEY, KIND_KEY);
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("summary: %0d bytes sent (%0d directed), %0d results checked, %0d records closed",
             n_sent, DIR_ROWS, n_checked, n_records);
    $display("summary: %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // receiver stalls in bursts, always ready once the run gets quiet
  initial ready_left = 0;
  always @(posedge clk) begin
    if (ready_left == 0 || quiet) begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        ready_next = 1'b1;
        ready_left = $urandom_range(1, 30);
      end else begin
        ready_next = 1'b0;
        ready_left = $urandom_range(1, 14);
      end
    end
    ready_left--;
    out_ready <= ready_next;
  end

  // outputs are stable at the falling edge; the transfer follows at the next rising edge
  initial begin
    n_checked = 0;
    n_records = 0;
    n_errors  = 0;
  end
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (kind == KIND_REC) n_records++;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d, out_byte %02h, out_last %0b",
               kind, out_byte, out_last);
        n_errors++;
      end else begin
        head = due_results.pop_front();
        if (kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, kind);
          n_errors++;
        end
        if (out_byte !== head.data) begin
          $error("out_byte: expected %02h, got %02h", head.data, out_byte);
          n_errors++;
        end
        if (out_last !== head.lst) begin
          $error("out_last: expected %0b, got %0b", head.lst, out_last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
